>>> hw/rtl/sha256_message_hasher_assert.svh
// Assertion macros for the message hasher.
`ifndef SHA256_MESSAGE_HASHER_ASSERT_SVH
`define SHA256_MESSAGE_HASHER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Check that a condition implies another in the next cycle.
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

>>> hw/rtl/sha_pkg.sv
`default_nettype none
package sha_pkg;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_present;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // One block handed from the packer to the compression core.
  typedef struct packed {
    logic [511:0] block;
    logic         final_blk;
  } blk_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [255:0] H_INIT = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    case (t)
      6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/sha256_message_hasher.sv
// Byte-stream SHA-256: one byte item per cycle into the packer while it does not stall.
// Each 64-byte block passes the round core in order: load, 64 rounds, add;
// the packer keeps filling the next block meanwhile, so sustained rate is about
// one byte per cycle. A final item may add a pad step, then 1-2 blocks, then 8 words.
// Synchronous active-low reset returns the chain to the initial hash values.
`default_nettype none
`include "sha256_message_hasher_assert.svh"
module sha256_message_hasher (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  sha_pkg::in_item_t      in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sha_pkg::out_item_t     out_item
);
  // Packer to queue, queue to core.
  logic          pq_valid, pq_stall, qc_valid, qc_stall;
  sha_pkg::blk_t pq_data, qc_data;

  // Front: collect bytes and pad the last block.
  sha_packer u_pack (
    .clk, .rst_n, .in_valid, .in_stall, .in_item,
    .blk_valid(pq_valid), .blk_stall(pq_stall), .blk_data(pq_data));

  // Queue: hold blocks so the packer keeps filling during rounds.
  sha_blk_queue u_q (
    .clk, .rst_n, .wr_valid(pq_valid), .wr_stall(pq_stall), .wr_data(pq_data),
    .rd_valid(qc_valid), .rd_stall(qc_stall), .rd_data(qc_data));

  // Back: compress and emit the digest.
  sha_core u_core (
    .clk, .rst_n, .blk_valid(qc_valid), .blk_stall(qc_stall), .blk_data(qc_data),
    .out_valid, .out_stall, .out_item);

  `SHA_ASSERT_IMP(a_last_idx, out_valid && out_item.last_word,
                  out_item.word_index == 3'd7)
  `SHA_ASSERT_NEXT(a_word_step, out_valid && !out_stall && !out_item.last_word,
                   out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1)
  `SHA_ASSERT_IMP(a_core_take, qc_valid && !qc_stall, !out_valid)
endmodule
`default_nettype wire

>>> hw/rtl/sha_packer.sv
`default_nettype none
// Front end: pack bytes, pad the final block and hand blocks to the queue.
module sha_packer (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  sha_pkg::in_item_t      in_item,
  output logic                   blk_valid,
  input  wire logic              blk_stall,
  output sha_pkg::blk_t          blk_data
);
  typedef enum logic [1:0] {S_FILL, S_PAD, S_PUSH} state_t;

  state_t        state_r;
  logic [511:0]  buf_r;
  logic [5:0]    fill_r;
  logic [63:0]   len_r;
  logic          push_final_r;  // block being pushed finishes the message
  logic          more_r;        // after the push, a padding block still follows
  logic          len_in_r;      // end marker already written into buf_r

  logic [511:0]  put_buf;
  logic [7:0]    put_val;

  assign in_stall  = (state_r != S_FILL);
  assign blk_valid = (state_r == S_PUSH);
  assign blk_data  = '{block: buf_r, final_blk: push_final_r};

  always_comb begin
    put_val = in_item.byte_present ? in_item.msg_byte : sha_pkg::PAD_BYTE;
    put_buf = buf_r;
    put_buf[511 - 8 * fill_r -: 8] = put_val;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_FILL;
      fill_r  <= '0;
      len_r   <= '0;
      push_final_r <= 1'b0;
      more_r  <= 1'b0;
      len_in_r <= 1'b0;
    end else begin
      case (state_r)
        S_FILL: begin
          if (in_valid) begin
            if (in_item.byte_present) begin
              buf_r  <= put_buf;
              fill_r <= fill_r + 6'd1;
              len_r  <= len_r + 64'd8;
              if (fill_r == 6'd63) begin
                push_final_r <= 1'b0;
                more_r   <= in_item.last_byte;
                len_in_r <= 1'b0;
                state_r  <= S_PUSH;
              end else if (in_item.last_byte) begin
                state_r <= S_PAD;
              end
            end else if (in_item.last_byte) begin
              state_r <= S_PAD;
            end
          end
        end
        S_PAD: begin
          // Mark end, clear the tail, drop in the length when it fits.
          for (int i = 0; i < 64; i++) begin
            if (i == fill_r) buf_r[511 - 8 * i -: 8] <= sha_pkg::PAD_BYTE;
            else if (i > fill_r && (i < 56 || fill_r >= 6'd56))
              buf_r[511 - 8 * i -: 8] <= 8'h00;
          end
          if (fill_r < 6'd56) begin
            buf_r[63:0]  <= len_r;
            push_final_r <= 1'b1;
            more_r       <= 1'b0;
          end else begin
            push_final_r <= 1'b0;
            more_r       <= 1'b1;
            len_in_r     <= 1'b1;
          end
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          if (!blk_stall) begin
            fill_r <= '0;
            if (more_r) begin
              // Second padding block: zeros and length, with the marker
              // only when the data ended right at a block edge.
              buf_r[511:64] <= {(len_in_r ? 8'h00 : sha_pkg::PAD_BYTE), 440'd0};
              buf_r[63:0]   <= len_r;
              push_final_r  <= 1'b1;
              more_r        <= 1'b0;
              len_in_r      <= 1'b0;
            end else begin
              if (push_final_r) len_r <= '0;
              state_r <= S_FILL;
            end
          end
        end
        default: state_r <= S_FILL;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/sha_blk_queue.sv
`default_nettype none
// Two-entry block queue between packer and core.
module sha_blk_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_valid,
  output logic            wr_stall,
  input  sha_pkg::blk_t   wr_data,
  output logic            rd_valid,
  input  wire logic       rd_stall,
  output sha_pkg::blk_t   rd_data
);
  sha_pkg::blk_t mem_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          wr, rd;

  assign wr_stall = (cnt_r == 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && !wr_stall;
  assign rd = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/sha_core.sv
`default_nettype none
// Back end: 64 rounds at one per cycle, chain update, digest emission.
module sha_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             blk_valid,
  output logic                  blk_stall,
  input  sha_pkg::blk_t         blk_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sha_pkg::out_item_t    out_item
);
  typedef enum logic [1:0] {S_IDLE, S_RUN, S_ADD, S_EMIT} state_t;

  state_t        state_r;
  logic [5:0]    t_r;
  logic [511:0]  w_r;     // rolling schedule, w[t] at the top
  logic [255:0]  h_r;
  logic [255:0]  v_r;     // a..h
  logic          final_r;
  logic [2:0]    idx_r;

  logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, wt, wn, w1, w14;

  assign blk_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_EMIT);
  assign out_item  = '{digest_word: h_r[255 - 32 * idx_r -: 32],
                       word_index: idx_r, last_word: (idx_r == 3'd7)};

  always_comb begin
    {a, b, c, d, e, f, g, hh} = v_r;
    wt  = w_r[511:480];
    w1  = w_r[479:448];
    w14 = w_r[63:32];
    t1 = hh + (sha_pkg::rotr(e, 6) ^ sha_pkg::rotr(e, 11) ^ sha_pkg::rotr(e, 25))
         + ((e & f) ^ (~e & g)) + sha_pkg::round_k(t_r) + wt;
    t2 = (sha_pkg::rotr(a, 2) ^ sha_pkg::rotr(a, 13) ^ sha_pkg::rotr(a, 22))
         + ((a & b) ^ (a & c) ^ (b & c));
    // w[t+16] = s1(w[t+14]) + w[t+9] + s0(w[t+1]) + w[t]
    wn = (sha_pkg::rotr(w14, 17) ^ sha_pkg::rotr(w14, 19) ^ (w14 >> 10))
         + w_r[223:192]
         + (sha_pkg::rotr(w1, 7) ^ sha_pkg::rotr(w1, 18) ^ (w1 >> 3)) + wt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      h_r     <= sha_pkg::H_INIT;
      t_r     <= '0;
      idx_r   <= '0;
      final_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (blk_valid) begin
            w_r     <= blk_data.block;
            final_r <= blk_data.final_blk;
            v_r     <= h_r;
            t_r     <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          v_r <= {t1 + t2, a, b, c, d + t1, e, f, g};
          w_r <= {w_r[479:0], wn};
          t_r <= t_r + 6'd1;
          if (t_r == 6'd63) state_r <= S_ADD;
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++)
            h_r[32 * i +: 32] <= h_r[32 * i +: 32] + v_r[32 * i +: 32];
          idx_r   <= '0;
          state_r <= final_r ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (!out_stall) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              h_r     <= sha_pkg::H_INIT;
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
